// ===== hdl/scbg_pkg.sv =====
// scbg_pkg: shared types, constants and the budget table of the call guard
// used by scbg_front, scbg_back and service_call_budget_guard
package scbg_pkg;

  localparam int NUM_SERVICES = 14;
  localparam int SLOT_W       = $clog2(NUM_SERVICES);
  localparam int ID_W         = 8;
  localparam int TICK_W       = 64;
  localparam int CNT_W        = 32;
  localparam int TPM_W        = 32;
  localparam int LIMIT_W      = 8;
  localparam int BUDGET_W     = 10;
  localparam int PROD_W       = TPM_W + BUDGET_W;
  localparam int CFG_DATA_W   = 32;

  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);

  localparam logic [TPM_W-1:0]   TICKS_RESET = TPM_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  // request codes on the input port
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_MS  = 1'b0;
  localparam logic CFG_FAILURE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_END,
    OP_QUERY,
    OP_INVALID
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic              success;
    logic [TICK_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic              granted;
    logic              id_valid;
    logic              available;
    logic              is_active;
    logic              is_disabled;
    logic [CNT_W-1:0]  call_count;
    logic [CNT_W-1:0]  failure_count;
    logic [CNT_W-1:0]  consecutive_count;
    logic [CNT_W-1:0]  overrun_count;
    logic [CNT_W-1:0]  denial_count;
    logic [TICK_W-1:0] last_duration;
  } res_t;

  // per-service budget in milliseconds
  function automatic logic [BUDGET_W-1:0] slot_budget(input logic [SLOT_W-1:0] slot);
    logic [BUDGET_W-1:0] b;
    case (slot)
      4'd0:    b = 10'd50;
      4'd1:    b = 10'd10;
      4'd2:    b = 10'd50;
      4'd3:    b = 10'd100;
      4'd4:    b = 10'd5;
      4'd5:    b = 10'd5;
      4'd6:    b = 10'd10;
      4'd7:    b = 10'd20;
      4'd8:    b = 10'd10;
      4'd9:    b = 10'd10;
      4'd10:   b = 10'd10;
      4'd11:   b = 10'd10;
      4'd12:   b = 10'd1000;
      4'd13:   b = 10'd1000;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/scbg_front.sv =====
// scbg_front: accepts requests, decodes kind and id range, queues them
// depends on scbg_pkg
module scbg_front import scbg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type_i,
  input  logic [ID_W-1:0]   service_id_i,
  input  logic              success_i,
  input  logic [TICK_W-1:0] now_ticks_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_PTR_W:0]   count_q;
  logic                  do_push, do_pop, id_ok;
  cmd_t                  cmd_in;

  assign id_ok = service_id_i < ID_W'(NUM_SERVICES);

  always_comb begin
    cmd_in.success = success_i;
    cmd_in.now     = now_ticks_i;
    cmd_in.slot    = id_ok ? service_id_i[SLOT_W-1:0] : '0;
    case (req_type_i)
      REQ_BEGIN: cmd_in.op = OP_BEGIN;
      REQ_END:   cmd_in.op = OP_END;
      REQ_QUERY: cmd_in.op = OP_QUERY;
      default:   cmd_in.op = OP_QUERY;
    endcase
    if (!id_ok) begin
      cmd_in.op = OP_INVALID;
    end
  end

  assign full        = count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hdl/scbg_back.sv =====
// scbg_back: per-service state, elapsed and budget check, result register
// depends on scbg_pkg
module scbg_back import scbg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic [TPM_W-1:0]   ticks_per_ms_i,
  input  logic [LIMIT_W-1:0] fail_cap_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_pop_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } st_e;

  st_e               state_q;
  cmd_t              cmd_q;
  logic [TICK_W-1:0] el_q;
  logic [PROD_W-1:0] prod_q;
  logic              res_valid_q;
  res_t              res_q;

  logic              act_q    [NUM_SERVICES];
  logic              dis_q    [NUM_SERVICES];
  logic [TICK_W-1:0] start_q  [NUM_SERVICES];
  logic [TICK_W-1:0] dur_q    [NUM_SERVICES];
  logic [CNT_W-1:0]  calls_q  [NUM_SERVICES];
  logic [CNT_W-1:0]  fails_q  [NUM_SERVICES];
  logic [CNT_W-1:0]  streak_q [NUM_SERVICES];
  logic [CNT_W-1:0]  ovr_q    [NUM_SERVICES];
  logic [CNT_W-1:0]  den_q    [NUM_SERVICES];

  logic              c_act, c_dis;
  logic              n_act, n_dis, grant, fail, overrun, commit_go;
  logic [TICK_W-1:0] n_dur;
  logic [CNT_W-1:0]  n_calls, n_fails, n_streak, n_ovr, n_den;
  res_t              res_d;

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign commit_go   = (state_q == ST_COMMIT) && (!res_valid_q || res_pop_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    c_act    = act_q[cmd_q.slot];
    c_dis    = dis_q[cmd_q.slot];
    n_act    = c_act;
    n_dis    = c_dis;
    n_dur    = dur_q[cmd_q.slot];
    n_calls  = calls_q[cmd_q.slot];
    n_fails  = fails_q[cmd_q.slot];
    n_streak = streak_q[cmd_q.slot];
    n_ovr    = ovr_q[cmd_q.slot];
    n_den    = den_q[cmd_q.slot];
    grant    = 1'b0;
    fail     = 1'b0;
    overrun  = (prod_q != '0) && (el_q > TICK_W'(prod_q));
    case (cmd_q.op)
      OP_BEGIN: begin
        if (!c_dis) begin
          if (c_act) begin
            n_den = n_den + 1'b1;
            fail  = 1'b1;
          end else begin
            n_act = 1'b1;
            grant = 1'b1;
          end
        end
      end
      OP_END: begin
        if (c_act) begin
          n_act   = 1'b0;
          n_dur   = el_q;
          n_calls = n_calls + 1'b1;
          if (overrun) begin
            n_ovr = n_ovr + 1'b1;
          end
          if (!cmd_q.success || overrun) begin
            fail = 1'b1;
          end else begin
            n_streak = '0;
          end
        end
      end
      default: ;
    endcase
    if (fail) begin
      n_fails  = n_fails + 1'b1;
      n_streak = n_streak + 1'b1;
      if (n_streak >= CNT_W'(fail_cap_i)) begin
        n_dis = 1'b1;
      end
    end

    res_d.granted           = grant;
    res_d.id_valid          = 1'b1;
    res_d.available         = !n_dis;
    res_d.is_active         = n_act;
    res_d.is_disabled       = n_dis;
    res_d.call_count        = n_calls;
    res_d.failure_count     = n_fails;
    res_d.consecutive_count = n_streak;
    res_d.overrun_count     = n_ovr;
    res_d.denial_count      = n_den;
    res_d.last_duration     = n_dur;
    if (cmd_q.op == OP_INVALID) begin
      res_d             = '0;
      res_d.is_disabled = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SERVICES; i++) begin
        act_q[i]    <= 1'b0;
        dis_q[i]    <= 1'b0;
        dur_q[i]    <= '0;
        calls_q[i]  <= '0;
        fails_q[i]  <= '0;
        streak_q[i] <= '0;
        ovr_q[i]    <= '0;
        den_q[i]    <= '0;
      end
    end else begin
      if (commit_go) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit_go) begin
            state_q              <= ST_IDLE;
            act_q[cmd_q.slot]    <= n_act;
            dis_q[cmd_q.slot]    <= n_dis;
            dur_q[cmd_q.slot]    <= n_dur;
            calls_q[cmd_q.slot]  <= n_calls;
            fails_q[cmd_q.slot]  <= n_fails;
            streak_q[cmd_q.slot] <= n_streak;
            ovr_q[cmd_q.slot]    <= n_ovr;
            den_q[cmd_q.slot]    <= n_den;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // request, elapsed time, budget product and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_CALC) begin
      el_q   <= cmd_q.now - start_q[cmd_q.slot];
      prod_q <= PROD_W'(ticks_per_ms_i) * PROD_W'(slot_budget(cmd_q.slot));
    end
    if (commit_go) begin
      res_q <= res_d;
      if (grant) begin
        start_q[cmd_q.slot] <= cmd_q.now;
      end
    end
  end

endmodule

// ===== hdl/service_call_budget_guard.sv =====
// service_call_budget_guard: top level of the per-service call guard
// depends on scbg_pkg, scbg_front and scbg_back
//
// requests enter through a queue port: an item is taken at a clock edge
// with push high and full low, and carries req_type, service_id, success
// and now_ticks. results leave through a queue port: while empty is low the
// oldest result is on the result ports, and it is taken at an edge with
// pop high. each request gives exactly one result, in request order.
// a request passes the queue, then back end states idle (request taken),
// calc (slot read and elapsed/budget product) and commit (compare and slot
// write); the back end takes no new request until the last has committed.
// a four-entry request queue takes new requests while a result waits; when
// pop stays low the finished result holds, the back end waits in commit and
// the request queue fills until full rises. reset clears per-service flags,
// durations and counters, not start ticks, sets ticks_per_ms to 1 and the
// failure limit to 3. the user must write the config port (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) only while no request is in flight; not enforced.
module service_call_budget_guard import scbg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            req_type_i,
  input  logic [ID_W-1:0]       service_id_i,
  input  logic                  success_i,
  input  logic [TICK_W-1:0]     now_ticks_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  granted_o,
  output logic                  id_valid_o,
  output logic                  available_o,
  output logic                  is_active_o,
  output logic                  is_disabled_o,
  output logic [CNT_W-1:0]      call_count_o,
  output logic [CNT_W-1:0]      failure_count_o,
  output logic [CNT_W-1:0]      consecutive_count_o,
  output logic [CNT_W-1:0]      overrun_count_o,
  output logic [CNT_W-1:0]      denial_count_o,
  output logic [TICK_W-1:0]     last_duration_o
);

  logic [TPM_W-1:0]   ticks_per_ms_q;
  logic [LIMIT_W-1:0] fail_cap_q;
  logic               cmd_valid, cmd_pop, res_valid;
  cmd_t               cmd;
  res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_ms_q <= TICKS_RESET;
      fail_cap_q     <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_MS:  ticks_per_ms_q <= cfg_wdata_i[TPM_W-1:0];
        CFG_FAILURE_LIMIT: fail_cap_q     <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  scbg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .service_id_i (service_id_i),
    .success_i    (success_i),
    .now_ticks_i  (now_ticks_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  scbg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .ticks_per_ms_i (ticks_per_ms_q),
    .fail_cap_i     (fail_cap_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_pop_i      (pop)
  );

  assign empty               = !res_valid;
  assign granted_o           = res.granted;
  assign id_valid_o          = res.id_valid;
  assign available_o         = res.available;
  assign is_active_o         = res.is_active;
  assign is_disabled_o       = res.is_disabled;
  assign call_count_o        = res.call_count;
  assign failure_count_o     = res.failure_count;
  assign consecutive_count_o = res.consecutive_count;
  assign overrun_count_o     = res.overrun_count;
  assign denial_count_o      = res.denial_count;
  assign last_duration_o     = res.last_duration;

  a_avail_vs_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (available_o != is_disabled_o))
    else $error("available and disabled disagree");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !id_valid_o) |-> (!granted_o && !is_active_o && call_count_o == '0))
    else $error("invalid id result carries state");

  a_grant_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && granted_o) |-> (is_active_o && available_o && id_valid_o))
    else $error("grant without active enabled slot");

endmodule
